// ----- src/qrm_pkg.sv -----
// Shared constants and types of the quaternion to rotation matrix block.
package qrm_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int IN_W = 16;
    localparam int OUT_W = 16;
    localparam int LANES = 9;
    localparam int PROD_W = 2 * IN_W;
    localparam int SUM_W = PROD_W + 3;
    localparam int N_W = PROD_W + 1;
    localparam int R_W = N_W + 1;

    typedef logic [LANES-1:0][R_W-1:0] lane_rem_t;
    typedef logic signed [PROD_W-1:0] prod_t;

endpackage

// ----- src/qrm_mult.sv -----
// Product stage and sum stage: squares, cross products, numerators and norm.
module qrm_mult
    import qrm_pkg::*;
(
    input  logic                   clk,
    input  logic                   en_prod,
    input  logic                   en_sum,
    input  logic signed [IN_W-1:0] quat_w,
    input  logic signed [IN_W-1:0] quat_x,
    input  logic signed [IN_W-1:0] quat_y,
    input  logic signed [IN_W-1:0] quat_z,
    output lane_rem_t              mag,
    output logic [LANES-1:0]       neg,
    output logic [N_W-1:0]         norm,
    output logic                   zero
);

    prod_t ww_reg, xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    lane_rem_t mag_reg, mag_next;
    logic [LANES-1:0] neg_reg, neg_next;
    logic [N_W-1:0] norm_reg, norm_next;
    logic zero_reg;
    logic signed [SUM_W-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz, n_s;
    logic signed [SUM_W-1:0] num [LANES];
    logic signed [SUM_W-1:0] a;

    always_ff @(posedge clk)
    begin
        if (en_prod)
        begin
            ww_reg <= prod_t'(quat_w) * prod_t'(quat_w);
            xx_reg <= prod_t'(quat_x) * prod_t'(quat_x);
            yy_reg <= prod_t'(quat_y) * prod_t'(quat_y);
            zz_reg <= prod_t'(quat_z) * prod_t'(quat_z);
            xy_reg <= prod_t'(quat_x) * prod_t'(quat_y);
            xz_reg <= prod_t'(quat_x) * prod_t'(quat_z);
            yz_reg <= prod_t'(quat_y) * prod_t'(quat_z);
            wx_reg <= prod_t'(quat_w) * prod_t'(quat_x);
            wy_reg <= prod_t'(quat_w) * prod_t'(quat_y);
            wz_reg <= prod_t'(quat_w) * prod_t'(quat_z);
        end
    end

    always_comb
    begin
        ww = SUM_W'(ww_reg);
        xx = SUM_W'(xx_reg);
        yy = SUM_W'(yy_reg);
        zz = SUM_W'(zz_reg);
        xy = SUM_W'(xy_reg);
        xz = SUM_W'(xz_reg);
        yz = SUM_W'(yz_reg);
        wx = SUM_W'(wx_reg);
        wy = SUM_W'(wy_reg);
        wz = SUM_W'(wz_reg);
        n_s = ww + xx + yy + zz;
        num[0] = ww + xx - yy - zz;
        num[1] = (xy + wz) <<< 1;
        num[2] = (xz - wy) <<< 1;
        num[3] = (xy - wz) <<< 1;
        num[4] = ww - xx + yy - zz;
        num[5] = (yz + wx) <<< 1;
        num[6] = (xz + wy) <<< 1;
        num[7] = (yz - wx) <<< 1;
        num[8] = ww - xx - yy + zz;
        norm_next = n_s[N_W-1:0];
        for (int i = 0; i < LANES; i++)
        begin
            a = num[i][SUM_W-1] ? -num[i] : num[i];
            neg_next[i] = num[i][SUM_W-1];
            mag_next[i] = {1'b0, a[N_W-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            mag_reg <= mag_next;
            neg_reg <= neg_next;
            norm_reg <= norm_next;
            zero_reg <= (norm_next == '0);
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;
    assign norm = norm_reg;
    assign zero = zero_reg;

endmodule

// ----- src/qrm_div_step.sv -----
// One restoring division step for all nine lanes against the shared norm.
module qrm_div_step
    import qrm_pkg::*;
#(
    parameter int QW = FRAC_BITS_DEF + 2
)
(
    input  logic                     clk,
    input  logic                     en,
    input  lane_rem_t                rem_in,
    input  logic [LANES-1:0][QW-1:0] q_in,
    input  logic [LANES-1:0]         neg_in,
    input  logic [N_W-1:0]           norm_in,
    input  logic                     zero_in,
    output lane_rem_t                rem_out,
    output logic [LANES-1:0][QW-1:0] q_out,
    output logic [LANES-1:0]         neg_out,
    output logic [N_W-1:0]           norm_out,
    output logic                     zero_out
);

    lane_rem_t rem_reg, rem_next;
    logic [LANES-1:0][QW-1:0] q_reg, q_next;
    logic [LANES-1:0] neg_reg;
    logic [N_W-1:0] norm_reg;
    logic zero_reg;
    logic [R_W-1:0] nx, t;
    logic bit_v;

    always_comb
    begin
        nx = {1'b0, norm_in};
        for (int i = 0; i < LANES; i++)
        begin
            bit_v = (rem_in[i] >= nx);
            t = bit_v ? (rem_in[i] - nx) : rem_in[i];
            rem_next[i] = {t[R_W-2:0], 1'b0};
            q_next[i] = {q_in[i][QW-2:0], bit_v};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            q_reg <= q_next;
            neg_reg <= neg_in;
            norm_reg <= norm_in;
            zero_reg <= zero_in;
        end
    end

    assign rem_out = rem_reg;
    assign q_out = q_reg;
    assign neg_out = neg_reg;
    assign norm_out = norm_reg;
    assign zero_out = zero_reg;

endmodule

// ----- src/qrm_round.sv -----
// Output stage: round to nearest, clamp to one, apply sign, saturate to 16 bits.
module qrm_round
    import qrm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                en,
    input  logic [LANES-1:0][FRAC_BITS+1:0]     q_in,
    input  logic [LANES-1:0]                    neg_in,
    input  logic                                zero_in,
    output logic [LANES-1:0][OUT_W-1:0]         m,
    output logic                                zero
);

    localparam int QW = FRAC_BITS + 2;
    localparam int SW = (QW + 1 > OUT_W + 1) ? QW + 1 : OUT_W + 1;
    localparam logic [QW-1:0] ONE = QW'(1) << FRAC_BITS;
    localparam logic signed [SW-1:0] MAXV = SW'(32767);
    localparam logic signed [SW-1:0] MINV = -SW'(32768);

    logic [LANES-1:0][OUT_W-1:0] m_reg, m_next;
    logic zero_reg;
    logic [QW:0] rsum;
    logic [QW-1:0] q;
    logic signed [SW-1:0] s;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            rsum = {1'b0, q_in[i]} + (QW+1)'(1);
            q = rsum[QW:1];
            if (q > ONE)
            begin
                q = ONE;
            end
            s = SW'($signed({1'b0, q}));
            if (neg_in[i])
            begin
                s = -s;
            end
            if (s > MAXV)
            begin
                s = MAXV;
            end
            if (s < MINV)
            begin
                s = MINV;
            end
            m_next[i] = zero_in ? '0 : s[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg <= m_next;
            zero_reg <= zero_in;
        end
    end

    assign m = m_reg;
    assign zero = zero_reg;

endmodule

// ----- src/quaternion_to_rotation_matrix.sv -----
// Top level of the quaternion to 3x3 rotation matrix pipeline.
// One request on the s_ channel carries a quaternion (w, x, y, z), each a
// signed Q1.14 value. One request on the m_ channel returns the nine entries
// of the rotation matrix of the normalized quaternion, each rounded to
// nearest and clamped to plus or minus one in Q(FRAC_BITS), plus a flag in
// m_tuser that marks an all-zero quaternion, for which all entries are zero.
// The block is a pipeline of FRAC_BITS + 5 register stages: one for the
// products, one for the sums, FRAC_BITS + 2 restoring division steps that
// share the norm across the nine entries, and one for rounding.
// One request can enter every cycle unless the pipeline is full and the
// receiver stalls. Every stage holds its own valid bit and a stage takes
// new data whenever it is empty or its successor moves, so bubbles close up
// while the receiver stalls and s_tready stays high until every stage is full.
// Reset clears all valid bits; data registers are not reset.
module quaternion_to_rotation_matrix
    import qrm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [4*IN_W-1:0]      s_tdata,  // quat_w, quat_x, quat_y, quat_z
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [LANES*OUT_W-1:0] m_tdata,  // m00, m10, m20, m01, m11, m21, m02, m12, m22
    output logic                   m_tuser   // zero_norm
);

    localparam int QW = FRAC_BITS + 2;
    localparam int STAGES = FRAC_BITS + 5;

    logic [STAGES-1:0] valid_reg, valid_next, en;

    lane_rem_t rem_s [QW+1];
    logic [LANES-1:0][QW-1:0] q_s [QW+1];
    logic [LANES-1:0] neg_s [QW+1];
    logic [N_W-1:0] norm_s [QW+1];
    logic zero_s [QW+1];
    logic [LANES-1:0][OUT_W-1:0] m_out;

    always_comb
    begin
        en[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        valid_next[0] = en[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < STAGES; i++)
        begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    qrm_mult u_mult (
        .clk     (clk),
        .en_prod (en[0]),
        .en_sum  (en[1]),
        .quat_w  (s_tdata[IN_W-1:0]),
        .quat_x  (s_tdata[2*IN_W-1:IN_W]),
        .quat_y  (s_tdata[3*IN_W-1:2*IN_W]),
        .quat_z  (s_tdata[4*IN_W-1:3*IN_W]),
        .mag     (rem_s[0]),
        .neg     (neg_s[0]),
        .norm    (norm_s[0]),
        .zero    (zero_s[0])
    );

    assign q_s[0] = '0;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        qrm_div_step #(.QW(QW)) u_step (
            .clk      (clk),
            .en       (en[k+2]),
            .rem_in   (rem_s[k]),
            .q_in     (q_s[k]),
            .neg_in   (neg_s[k]),
            .norm_in  (norm_s[k]),
            .zero_in  (zero_s[k]),
            .rem_out  (rem_s[k+1]),
            .q_out    (q_s[k+1]),
            .neg_out  (neg_s[k+1]),
            .norm_out (norm_s[k+1]),
            .zero_out (zero_s[k+1])
        );
    end

    qrm_round #(.FRAC_BITS(FRAC_BITS)) u_round (
        .clk     (clk),
        .en      (en[STAGES-1]),
        .q_in    (q_s[QW]),
        .neg_in  (neg_s[QW]),
        .zero_in (zero_s[QW]),
        .m       (m_out),
        .zero    (m_tuser)
    );

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[STAGES-1];
    assign m_tdata = m_out;

    a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("zero quaternion gave a nonzero matrix");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while the output stage is empty");

    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted request did not enter the pipeline");

endmodule
